FILE: rtl/grouped_bitmap_block_allocator_macros.svh
// Assertion macros used by the checker file of the bitmap allocator.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// The consequence must hold at the same edge as the trigger.
`define GBBA_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap allocator check failed");

// The consequence must hold at the edge after the trigger.
`define GBBA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap allocator check failed");

`endif

FILE: rtl/gbba_pkg.sv
package gbba_pkg;

	// Default geometry of the bitmap store.
	localparam int DEF_MAX_GROUPS     = 8;
	localparam int DEF_BITS_PER_GROUP = 8192;

	// Field widths of the beats and of the configuration port.
	localparam int HINT_W    = 16;
	localparam int BLK_W     = 17;
	localparam int GUSED_W   = 14;
	localparam int BPG_W     = 14;
	localparam int IPG_W     = 16;
	localparam int GCNT_W    = 4;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W     = 17;

	// Register values after reset.
	localparam logic [BPG_W-1:0]  RST_BPG = 14'd8192;
	localparam logic [IPG_W-1:0]  RST_IPG = 16'd2048;
	localparam logic              RST_FDB = 1'b1;
	localparam logic [GCNT_W-1:0] RST_GC  = 4'd8;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FREE  = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BPG = 2'd0,
		CFG_IPG = 2'd1,
		CFG_FDB = 2'd2,
		CFG_GC  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_SCAN,
		S_ALLOC_WR,
		S_FREE_RD,
		S_FREE_CHK,
		S_RESP
	} state_t;

	// Quotient and remainder handed back by the divider.
	typedef struct packed {
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_res_t;

endpackage

FILE: rtl/gbba_div.sv
module gbba_div import gbba_pkg::*; #(
	parameter int MAX_GROUPS = DEF_MAX_GROUPS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [DIV_W-1:0]                         dividend,
	input  logic [DIV_W-1:0]                         divisor,
	input  logic [$clog2(MAX_GROUPS+1)-1:0]          modulus,
	output logic                                     done,
	output div_res_t                                 res,
	output logic [(MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1)-1:0] qmod
);

	localparam int GC_W   = $clog2(MAX_GROUPS + 1);
	localparam int G_W    = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
	localparam int STEP_W = $clog2(DIV_W + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [GC_W-1:0]   mod_q;
	logic [GC_W-1:0]   qmod_q;

	logic [DIV_W:0]    trial;
	logic              ge;
	logic [DIV_W-1:0]  rem_n;
	logic [GC_W:0]     mtrial;
	logic              mge;
	logic [GC_W-1:0]   qmod_n;

	// One restoring step: shift in the next dividend bit and try the subtract.
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		rem_n = ge ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
	end

	// The quotient bits arrive most significant first, so its residue modulo
	// the group count is built with one shift and conditional subtract.
	always_comb begin
		mtrial = {qmod_q, ge};
		mge    = mtrial >= {1'b0, mod_q};
		qmod_n = mge ? GC_W'(mtrial - {1'b0, mod_q}) : GC_W'(mtrial);
	end

	// Sequencer of the divide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && (step_q == STEP_W'(1));
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(DIV_W);
			end else if (run_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			mod_q  <= modulus;
			qmod_q <= '0;
		end else if (run_q) begin
			rem_q  <= rem_n;
			quo_q  <= {quo_q[DIV_W-2:0], ge};
			qmod_q <= qmod_n;
		end
	end

	assign done     = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;
	assign qmod     = G_W'(qmod_q);

endmodule

FILE: rtl/grouped_bitmap_block_allocator.sv
// Block allocator over a bitmap split into block groups, one bit per block.
// Input channel (in_valid/in_ready) takes one beat per request: func selects an
// allocate, steered by hint_number, or a free of block_to_free. Output channel
// (out_valid/out_ready) returns one beat per request with status, the block
// handed out and the used counts after the request.
// Configuration registers are written through cfg_write/cfg_index/cfg_data
// by the user, only while no request is in flight; the block does not enforce it.
// An allocate runs the serial divide for the preferred group (17 steps and a
// done strobe), then scans the bitmap memory one 64-bit word per cycle from that
// group with wrap-around; on a free bit it writes the word back with that bit set,
// and if no word has one the result is FULL. A free runs the divide, reads the
// word and clears the bit if it was set; a free below the first block number skips
// the divide and the memory, and one past the group count skips only the memory.
// The bitmap memory has a write port and a read port; one request is handled at a
// time, and the next beat is taken once the result is in the output register.
// After reset the bitmap memory is cleared by a pass over its MAX_GROUPS times
// ceil(BITS_PER_GROUP/64) words (1024 by default), during which in_ready is low.
// A result waits in the output register while out_ready is low; the next
// request is taken meanwhile, and its result waits until the register frees.
module grouped_bitmap_block_allocator import gbba_pkg::*; #(
	parameter int MAX_GROUPS     = DEF_MAX_GROUPS,
	parameter int BITS_PER_GROUP = DEF_BITS_PER_GROUP
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [HINT_W-1:0]    hint_number,
	input  logic [BLK_W-1:0]     block_to_free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [BLK_W-1:0]     allocated_block,
	output logic [GUSED_W-1:0]   group_used,
	output logic [BLK_W-1:0]     total_used,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int WPG   = (BITS_PER_GROUP + 63) / 64;
	localparam int DEPTH = MAX_GROUPS * WPG;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int W_W   = WPG > 1 ? $clog2(WPG) : 1;
	localparam int G_W   = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
	localparam int GC_W  = $clog2(MAX_GROUPS + 1);
	localparam int BW    = $clog2(BITS_PER_GROUP + 1);
	localparam int CNT_W = $clog2(BITS_PER_GROUP + 1);
	localparam int TOT_W = $clog2(MAX_GROUPS * BITS_PER_GROUP + 1);

	state_t state_q, state_d;

	// Configuration registers.
	logic [BPG_W-1:0]  bpg_q;
	logic [IPG_W-1:0]  ipg_q;
	logic              fdb_q;
	logic [GCNT_W-1:0] gc_q;

	// Bitmap memory and its port signals.
	logic [63:0]    bitmap_q [DEPTH];
	logic [63:0]    mem_rd_q;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [63:0]    mem_wdata;
	logic           mem_re;
	logic [AW-1:0]  mem_raddr;
	logic [AW-1:0]  clr_addr_q;

	// Used counts.
	logic [CNT_W-1:0] cnt_q [MAX_GROUPS];
	logic [TOT_W-1:0] total_q;
	logic [CNT_W-1:0] cur_cnt;

	// Request and scan registers.
	logic             op_free_q;
	logic [G_W-1:0]   cur_g_q;
	logic [W_W-1:0]   sel_w_q;
	logic [5:0]       sel_bit_q;
	logic [63:0]      hit_word_q;
	logic [G_W-1:0]   scan_g_q;
	logic [W_W-1:0]   scan_w_q;
	logic [GC_W-1:0]  scan_a_q;
	logic             issue_done_q;
	logic             rd_v_s1;
	logic [G_W-1:0]   rd_g_s1;
	logic [W_W-1:0]   rd_w_s1;
	logic             rd_last_s1;
	logic             rd_final_s1;

	// Pending result and output registers.
	status_t              res_status_q;
	logic [BLK_W-1:0]     res_block_q;
	logic [GUSED_W-1:0]   res_gused_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [BLK_W-1:0]     out_block_q;
	logic [GUSED_W-1:0]   out_gused_q;
	logic [BLK_W-1:0]     out_total_q;

	// Effective geometry and helpers.
	logic [GC_W-1:0]  gc_eff;
	logic [BW-1:0]    bpg_eff;
	logic [BW-1:0]    bpg_m1;
	logic [W_W-1:0]   last_w;
	logic [IPG_W-1:0] ipg_eff;
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_divisor;
	logic             div_start;
	logic             div_done;
	div_res_t         div_res;
	logic [G_W-1:0]   div_qmod;
	logic             accept;
	logic             early_range;
	logic             word_last;
	logic             grp_last;
	logic [G_W-1:0]   scan_g_next;
	logic [63:0]      scan_mask;
	logic [63:0]      free_bits;
	logic [63:0]      low_bit;
	logic [5:0]       low_idx;
	logic             hit;
	logic [63:0]      sel_mask;
	logic             free_bit_set;
	logic [BLK_W-1:0] alloc_block;
	logic             resp_load;

	function automatic logic [AW-1:0] word_addr(input logic [G_W-1:0] g,
			input logic [W_W-1:0] w);
		return AW'(32'(g) * WPG + 32'(w));
	endfunction

	// Out-of-range register values are clamped to the usable range.
	always_comb begin
		if (gc_q == '0) begin
			gc_eff = GC_W'(1);
		end else if (32'(gc_q) > MAX_GROUPS) begin
			gc_eff = GC_W'(MAX_GROUPS);
		end else begin
			gc_eff = GC_W'(gc_q);
		end
		if (bpg_q == '0) begin
			bpg_eff = BW'(1);
		end else if (32'(bpg_q) > BITS_PER_GROUP) begin
			bpg_eff = BW'(BITS_PER_GROUP);
		end else begin
			bpg_eff = BW'(bpg_q);
		end
		ipg_eff = (ipg_q == '0) ? IPG_W'(1) : ipg_q;
		bpg_m1  = bpg_eff - BW'(1);
		last_w  = W_W'(bpg_m1 >> 6);
	end

	// Divider operands: the hint picks the preferred group, a freed block
	// number splits into group and bit.
	assign accept      = in_valid && in_ready;
	assign early_range = (func == FUNC_FREE) && (block_to_free < BLK_W'(fdb_q));
	always_comb begin
		if (func == FUNC_FREE) begin
			div_dividend = DIV_W'(block_to_free - BLK_W'(fdb_q));
			div_divisor  = DIV_W'(bpg_eff);
		end else begin
			div_dividend = (hint_number == '0) ? '0 : DIV_W'(hint_number - HINT_W'(1));
			div_divisor  = DIV_W'(ipg_eff);
		end
	end

	gbba_div #(
		.MAX_GROUPS(MAX_GROUPS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.modulus (gc_eff),
		.done    (div_done),
		.res     (div_res),
		.qmod    (div_qmod)
	);

	// Scan pointer stepping: words within a group, then the next group with wrap.
	always_comb begin
		word_last = (scan_w_q == last_w);
		grp_last  = (scan_a_q == gc_eff);
		if (32'(scan_g_q) + 1 == 32'(gc_eff)) begin
			scan_g_next = '0;
		end else begin
			scan_g_next = scan_g_q + G_W'(1);
		end
	end

	// Lowest free bit of the word read last cycle, within the group's size.
	always_comb begin
		if (rd_last_s1 && (bpg_eff[5:0] != 6'd0)) begin
			scan_mask = (64'd1 << bpg_eff[5:0]) - 64'd1;
		end else begin
			scan_mask = '1;
		end
		free_bits = ~mem_rd_q & scan_mask;
		low_bit   = free_bits & (~free_bits + 64'd1);
		low_idx   = '0;
		for (int i = 0; i < 64; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | 6'(i);
			end
		end
		hit = (state_q == S_SCAN) && rd_v_s1 && (free_bits != '0);
	end

	assign cur_cnt      = cnt_q[cur_g_q];
	assign sel_mask     = 64'd1 << sel_bit_q;
	assign free_bit_set = mem_rd_q[sel_bit_q];
	assign alloc_block  = BLK_W'(32'(fdb_q) + 32'(cur_g_q) * 32'(bpg_eff)
		+ 32'({sel_w_q, sel_bit_q}));
	assign resp_load    = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		div_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (early_range) begin
						state_d = S_RESP;
					end else begin
						div_start = 1'b1;
						state_d   = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (!op_free_q) begin
						state_d = S_SCAN;
					end else if (div_res.quot >= DIV_W'(gc_eff)) begin
						state_d = S_RESP;
					end else begin
						state_d = S_FREE_RD;
					end
				end
			end
			S_SCAN: begin
				mem_re    = !issue_done_q;
				mem_raddr = word_addr(scan_g_q, scan_w_q);
				if (hit) begin
					state_d = S_ALLOC_WR;
				end else if (rd_v_s1 && rd_final_s1) begin
					state_d = S_RESP;
				end
			end
			S_ALLOC_WR: begin
				mem_we    = 1'b1;
				mem_waddr = word_addr(cur_g_q, sel_w_q);
				mem_wdata = hit_word_q | sel_mask;
				state_d   = S_RESP;
			end
			S_FREE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = word_addr(cur_g_q, sel_w_q);
				state_d   = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				if (free_bit_set) begin
					mem_we    = 1'b1;
					mem_waddr = word_addr(cur_g_q, sel_w_q);
					mem_wdata = mem_rd_q & ~sel_mask;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Bitmap memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= bitmap_q[mem_raddr];
		end
	end

	// Control registers: configuration, clearing pass, counts, scan flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpg_q        <= RST_BPG;
			ipg_q        <= RST_IPG;
			fdb_q        <= RST_FDB;
			gc_q         <= RST_GC;
			clr_addr_q   <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
			issue_done_q <= 1'b0;
			rd_v_s1      <= 1'b0;
			for (int g = 0; g < MAX_GROUPS; g++) begin
				cnt_q[g] <= '0;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BPG: bpg_q <= cfg_data[BPG_W-1:0];
					CFG_IPG: ipg_q <= cfg_data[IPG_W-1:0];
					CFG_FDB: fdb_q <= cfg_data[0];
					CFG_GC:  gc_q  <= cfg_data[GCNT_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_DIV && div_done) begin
				issue_done_q <= 1'b0;
				rd_v_s1      <= 1'b0;
			end else if (state_q == S_SCAN) begin
				rd_v_s1      <= !issue_done_q;
				issue_done_q <= issue_done_q || (word_last && grp_last);
			end
			if (state_q == S_ALLOC_WR) begin
				cnt_q[cur_g_q] <= cur_cnt + CNT_W'(1);
				total_q        <= total_q + TOT_W'(1);
			end
			if (state_q == S_FREE_CHK && free_bit_set) begin
				if (cur_cnt != '0) begin
					cnt_q[cur_g_q] <= cur_cnt - CNT_W'(1);
				end
				if (total_q != '0) begin
					total_q <= total_q - TOT_W'(1);
				end
			end
		end
	end

	// Datapath registers of the request in flight and of the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_free_q    <= (func == FUNC_FREE);
			res_status_q <= STAT_RANGE;
			res_block_q  <= '0;
			res_gused_q  <= '0;
		end
		if (state_q == S_DIV && div_done) begin
			if (op_free_q) begin
				cur_g_q   <= G_W'(div_res.quot);
				sel_w_q   <= W_W'(div_res.rem >> 6);
				sel_bit_q <= div_res.rem[5:0];
			end else begin
				cur_g_q  <= div_qmod;
				scan_g_q <= div_qmod;
				scan_w_q <= '0;
				scan_a_q <= GC_W'(1);
			end
		end
		if (state_q == S_SCAN) begin
			if (!issue_done_q) begin
				rd_g_s1     <= scan_g_q;
				rd_w_s1     <= scan_w_q;
				rd_last_s1  <= word_last;
				rd_final_s1 <= word_last && grp_last;
				if (word_last) begin
					scan_w_q <= '0;
					scan_g_q <= scan_g_next;
					scan_a_q <= scan_a_q + GC_W'(1);
				end else begin
					scan_w_q <= scan_w_q + W_W'(1);
				end
			end
			if (hit) begin
				cur_g_q    <= rd_g_s1;
				sel_w_q    <= rd_w_s1;
				sel_bit_q  <= low_idx;
				hit_word_q <= mem_rd_q;
			end else if (rd_v_s1 && rd_final_s1) begin
				res_status_q <= STAT_FULL;
				res_block_q  <= '0;
				res_gused_q  <= GUSED_W'(cur_cnt);
			end
		end
		if (state_q == S_ALLOC_WR) begin
			res_status_q <= STAT_OK;
			res_block_q  <= alloc_block;
			res_gused_q  <= GUSED_W'(cur_cnt + CNT_W'(1));
		end
		if (state_q == S_FREE_CHK) begin
			res_block_q <= '0;
			if (free_bit_set) begin
				res_status_q <= STAT_OK;
				res_gused_q  <= (cur_cnt == '0) ? '0 : GUSED_W'(cur_cnt - CNT_W'(1));
			end else begin
				res_status_q <= STAT_FREE;
				res_gused_q  <= GUSED_W'(cur_cnt);
			end
		end
		if (resp_load) begin
			out_status_q <= res_status_q;
			out_block_q  <= res_block_q;
			out_gused_q  <= res_gused_q;
			out_total_q  <= BLK_W'(total_q);
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign allocated_block = out_block_q;
	assign group_used      = out_gused_q;
	assign total_used      = out_total_q;

endmodule

FILE: rtl/gbba_checker.sv
`include "grouped_bitmap_block_allocator_macros.svh"

module gbba_checker import gbba_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [1:0]           status,
	input logic [BLK_W-1:0]     allocated_block,
	input logic [GUSED_W-1:0]   group_used,
	input logic [BLK_W-1:0]     total_used
);

	// A request keeps the block busy for at least the next cycle.
	`GBBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// A stalled result beat holds.
	`GBBA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(allocated_block) && $stable(group_used) && $stable(total_used))

	// Only a successful allocate hands out a block number.
	`GBBA_ASSERT_SAME(a_fail_no_block, clk, arst_n, out_valid && status != STAT_OK, allocated_block == '0)

	// A rejected free touches no group.
	`GBBA_ASSERT_SAME(a_range_no_group, clk, arst_n, out_valid && status == STAT_RANGE, group_used == '0)

endmodule

bind grouped_bitmap_block_allocator gbba_checker u_gbba_checker (.*);
